// ----- rtl/dltq_pkg.sv -----
// Shared types, codes and defaults for the delta-list timer queue.
package dltq_pkg;

  localparam int TIMER_SLOTS_DEF = 16;
  localparam int MAX_RESULTS     = 16;
  localparam int DELTA_W         = 16;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_STOP  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [2:0] ST_STARTED    = 3'd0;
  localparam logic [2:0] ST_ALREADY    = 3'd1;
  localparam logic [2:0] ST_STOPPED    = 3'd2;
  localparam logic [2:0] ST_NOT_QUEUED = 3'd3;
  localparam logic [2:0] ST_EXPIRED    = 3'd4;
  localparam logic [2:0] ST_NO_EXPIRY  = 3'd5;

  typedef enum logic {
    ALU_SUB = 1'b0,
    ALU_ADD = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  timer_id;
    logic [15:0] ticks;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] slot_out;
    logic       last;
  } out_beat_t;

endpackage

// ----- rtl/dltq_alu.sv -----
// Shared add/subtract unit with borrow out, used for the delta arithmetic.
module dltq_alu
  import dltq_pkg::*;
(
  input  alu_op_t              op,
  input  logic [DELTA_W-1:0]   a,
  input  logic [DELTA_W-1:0]   b,
  output logic [DELTA_W:0]     res
);

  // Extend by one bit so the top bit carries borrow or carry
  always_comb begin
    unique case (op)
      ALU_SUB: res = {1'b0, a} - {1'b0, b};
      ALU_ADD: res = {1'b0, a} + {1'b0, b};
      default: res = '0;
    endcase
  end

endmodule

// ----- rtl/delta_list_timer_queue.sv -----
// Top level: delta-list timer queue with list tables and command sequencer.
//
// Usage: drive in_beat and raise start while busy is low; the beat is taken
// at that edge. Results come out on out_beat for exactly one cycle each,
// marked by out_strobe; the receiver cannot hold them off. The final result
// of a command has last set.
//
// While busy after the accepting edge: start walks one entry per cycle past at
// most TIMER_SLOTS - 1 queued entries, links the new slot in, then reduces the
// delta of the entry after it, if any. Stop walks the entries ahead of the
// slot, unlinks it and adds its delta to the entry after it. A tick counts down
// the head, then pops at most 16 expiries, one expiry beat per cycle. Rejected
// commands, a tick on an empty list and the unused command keep busy low and
// answer in the cycle after the accepting edge. The next command can be taken
// at the first edge with busy low. The single add/subtract unit and one table
// read per cycle make each command step through its states in turn.
//
// Reset clears all slots to idle with an empty list; busy is held high
// during reset and a command is taken at the first edge after release.
module delta_list_timer_queue
  import dltq_pkg::*;
#(
  parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_beat_t  in_beat,
  output logic      out_strobe,
  output out_beat_t out_beat
);

  localparam int LW = $clog2(TIMER_SLOTS + 1);
  localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam logic [LW-1:0] NIL = LW'(TIMER_SLOTS);
  localparam int CW = $clog2(MAX_RESULTS + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_WALK  = 9'b000000010,
    S_INS   = 9'b000000100,
    S_FIX   = 9'b000001000,
    S_SWALK = 9'b000010000,
    S_SID   = 9'b000100000,
    S_SFIX  = 9'b001000000,
    S_TDEC  = 9'b010000000,
    S_TEXP  = 9'b100000000
  } state_t;

  state_t state_r;

  logic [DELTA_W-1:0] delta_r [TIMER_SLOTS];
  logic [LW-1:0]      next_r  [TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0] queued_r;
  logic [LW-1:0]      head_r;

  logic [LW-1:0]      id_r, cur_r, prev_r;
  logic [DELTA_W-1:0] t_r;
  logic [CW-1:0]      cnt_r;
  logic               pend_r;
  logic [3:0]         pend_slot_r;
  logic [3:0]         id_in_r;

  logic               out_strobe_r;
  out_beat_t          out_beat_r;

  // Table read port: one address per cycle, chosen by state
  logic [LW-1:0]      rd_addr;
  logic [DELTA_W-1:0] rd_delta;
  logic [LW-1:0]      rd_next;

  always_comb begin
    unique case (state_r)
      S_SID:   rd_addr = id_r;
      S_TDEC,
      S_TEXP:  rd_addr = head_r;
      default: rd_addr = cur_r;
    endcase
  end

  assign rd_delta = delta_r[rd_addr[IW-1:0]];
  assign rd_next  = next_r[rd_addr[IW-1:0]];

  // Shared arithmetic unit operand selection
  alu_op_t            alu_op;
  logic [DELTA_W-1:0] alu_a, alu_b;
  logic [DELTA_W:0]   alu_res;

  always_comb begin
    unique case (state_r)
      S_WALK: begin
        alu_op = ALU_SUB; alu_a = t_r; alu_b = rd_delta;
      end
      S_FIX: begin
        alu_op = ALU_SUB; alu_a = rd_delta; alu_b = t_r;
      end
      S_SFIX: begin
        alu_op = ALU_ADD; alu_a = rd_delta; alu_b = t_r;
      end
      S_TDEC: begin
        alu_op = ALU_SUB; alu_a = rd_delta; alu_b = DELTA_W'(1);
      end
      default: begin
        alu_op = ALU_SUB; alu_a = t_r; alu_b = rd_delta;
      end
    endcase
  end

  dltq_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  logic cur_live, prev_live, head_live, rd_lt, in_ok, in_queued;
  logic [IW-1:0] in_idx;
  assign cur_live  = cur_r < NIL;
  assign prev_live = prev_r < NIL;
  assign head_live = head_r < NIL;
  // delta < t: no borrow and non-zero difference
  assign rd_lt     = !alu_res[DELTA_W] && (alu_res[DELTA_W-1:0] != '0);
  assign in_ok     = 32'(in_beat.timer_id) < TIMER_SLOTS;
  assign in_idx    = IW'(in_beat.timer_id);
  assign in_queued = in_ok && queued_r[in_idx];

  // Sequencer and table updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= NIL;
      queued_r     <= '0;
      out_strobe_r <= 1'b0;
      pend_r       <= 1'b0;
      cnt_r        <= '0;
      for (int i = 0; i < TIMER_SLOTS; i++) begin
        delta_r[i] <= '0;
        next_r[i]  <= NIL;
      end
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            id_r    <= LW'(in_beat.timer_id);
            id_in_r <= in_beat.timer_id;
            prev_r  <= NIL;
            cur_r   <= head_r;
            t_r     <= (in_beat.ticks == '0) ? DELTA_W'(1) : in_beat.ticks;
            unique case (in_beat.command)
              CMD_START: begin
                if (!in_ok || in_queued) begin
                  out_strobe_r <= 1'b1;
                  out_beat_r   <= '{ST_ALREADY, in_beat.timer_id, 1'b1};
                end else begin
                  state_r <= S_WALK;
                end
              end
              CMD_STOP: begin
                if (!in_ok || !in_queued) begin
                  out_strobe_r <= 1'b1;
                  out_beat_r   <= '{ST_NOT_QUEUED, in_beat.timer_id, 1'b1};
                end else begin
                  state_r <= S_SWALK;
                end
              end
              default: begin
                if (in_beat.command == CMD_TICK && head_live) begin
                  cnt_r   <= '0;
                  pend_r  <= 1'b0;
                  state_r <= S_TDEC;
                end else begin
                  out_strobe_r <= 1'b1;
                  out_beat_r   <= '{ST_NO_EXPIRY, 4'd0, 1'b1};
                end
              end
            endcase
          end
        end
        // Advance past entries whose delta is smaller than what remains
        S_WALK: begin
          if (cur_live && rd_lt) begin
            t_r    <= alu_res[DELTA_W-1:0];
            prev_r <= cur_r;
            cur_r  <= rd_next;
          end else begin
            state_r <= S_INS;
          end
        end
        // Link the new slot ahead of the current entry
        S_INS: begin
          delta_r[id_r[IW-1:0]] <= t_r;
          next_r[id_r[IW-1:0]]  <= cur_live ? cur_r : NIL;
          queued_r[id_r[IW-1:0]] <= 1'b1;
          if (prev_live) next_r[prev_r[IW-1:0]] <= id_r;
          else           head_r <= id_r;
          if (cur_live) begin
            state_r <= S_FIX;
          end else begin
            out_strobe_r <= 1'b1;
            out_beat_r   <= '{ST_STARTED, id_in_r, 1'b1};
            state_r      <= S_IDLE;
          end
        end
        // Reduce the successor's delta by the inserted one
        S_FIX: begin
          delta_r[cur_r[IW-1:0]] <= alu_res[DELTA_W-1:0];
          out_strobe_r <= 1'b1;
          out_beat_r   <= '{ST_STARTED, id_in_r, 1'b1};
          state_r      <= S_IDLE;
        end
        // Find the predecessor of the slot being stopped
        S_SWALK: begin
          if (cur_live && cur_r != id_r) begin
            prev_r <= cur_r;
            cur_r  <= rd_next;
          end else begin
            state_r <= S_SID;
          end
        end
        // Unlink the slot and hold its delta for the successor
        S_SID: begin
          t_r   <= rd_delta;
          cur_r <= rd_next;
          if (prev_live) next_r[prev_r[IW-1:0]] <= rd_next;
          else           head_r <= rd_next;
          next_r[id_r[IW-1:0]]   <= NIL;
          queued_r[id_r[IW-1:0]] <= 1'b0;
          state_r <= S_SFIX;
        end
        S_SFIX: begin
          if (cur_live) delta_r[cur_r[IW-1:0]] <= alu_res[DELTA_W-1:0];
          out_strobe_r <= 1'b1;
          out_beat_r   <= '{ST_STOPPED, id_in_r, 1'b1};
          state_r      <= S_IDLE;
        end
        // Count down the head unless it is already at zero
        S_TDEC: begin
          if (rd_delta != '0) delta_r[head_r[IW-1:0]] <= alu_res[DELTA_W-1:0];
          state_r <= S_TEXP;
        end
        // Pop zero-delta heads; each beat is held back until the next pop to know last
        S_TEXP: begin
          if (head_live && rd_delta == '0 && cnt_r < CW'(MAX_RESULTS)) begin
            head_r <= rd_next;
            next_r[head_r[IW-1:0]]   <= NIL;
            queued_r[head_r[IW-1:0]] <= 1'b0;
            if (pend_r) begin
              out_strobe_r <= 1'b1;
              out_beat_r   <= '{ST_EXPIRED, pend_slot_r, 1'b0};
            end
            pend_r      <= 1'b1;
            pend_slot_r <= 4'(head_r);
            cnt_r       <= cnt_r + CW'(1);
          end else begin
            out_strobe_r <= 1'b1;
            out_beat_r   <= pend_r ? out_beat_t'{ST_EXPIRED, pend_slot_r, 1'b1}
                                   : out_beat_t'{ST_NO_EXPIRY, 4'd0, 1'b1};
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Hold busy high while reset is applied
  assign busy       = (state_r != S_IDLE) || !rst_n;
  assign out_strobe = out_strobe_r;
  assign out_beat   = out_beat_r;

endmodule
